// ===== rtl/rci_pkg.sv =====
// shared types, constants and arithmetic helpers for the ray/cone intersection pipeline
package rci_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_APEX_X = 3'd0;
  localparam logic [2:0] REG_APEX_Y = 3'd1;
  localparam logic [2:0] REG_APEX_Z = 3'd2;
  localparam logic [2:0] REG_AXIS_X = 3'd3;
  localparam logic [2:0] REG_AXIS_Y = 3'd4;
  localparam logic [2:0] REG_AXIS_Z = 3'd5;
  localparam logic [2:0] REG_COS_SQ = 3'd6;
  localparam logic [2:0] REG_FAR    = 3'd7;

  // saturation limits
  localparam logic signed [127:0] LIM_W  = 128'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [62:0]  LIM63  = 63'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0]  HALF64 = 64'sh1FFF_FFFF_FFFF_FFFF;
  localparam logic [30:0]         DIST_SAT = 31'h7FFF_FFFF;
  localparam logic signed [50:0]  S32_MAX = 51'sd2147483647;
  localparam logic signed [50:0]  S32_MIN = -51'sd2147483648;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [17:0] unit_t;

  typedef struct packed {
    coord_t [2:0] o;
    unit_t  [2:0] d;
  } ray_t;

  // partial products of a 54 x 54 signed multiply
  typedef struct packed {
    logic signed [55:0] ll;
    logic signed [54:0] lh;
    logic signed [54:0] hl;
    logic signed [53:0] hh;
  } part54_t;

  // partial products of a 64 x 64 signed multiply
  typedef struct packed {
    logic signed [65:0] ll;
    logic signed [64:0] lh;
    logic signed [64:0] hl;
    logic signed [63:0] hh;
  } part64_t;

  // per-item flags travelling through the dividers
  typedef struct packed {
    logic ovfn;
    logic ovfp;
    logic negn;
    logic negp;
    logic aneg;
    logic miss;
  } div_side_t;

  function automatic part54_t pmul54(input logic signed [53:0] x,
                                     input logic signed [53:0] y);
    part54_t p;
    logic signed [27:0] xl, yl;
    logic signed [26:0] xh, yh;
    xl = $signed({1'b0, x[26:0]});
    yl = $signed({1'b0, y[26:0]});
    xh = x[53:27];
    yh = y[53:27];
    p.ll = xl * yl;
    p.lh = xl * yh;
    p.hl = xh * yl;
    p.hh = xh * yh;
    return p;
  endfunction

  function automatic logic signed [107:0] pjoin54(input part54_t p);
    logic signed [107:0] hh, mid, ll;
    hh  = 108'($signed(p.hh));
    mid = 108'($signed(p.lh)) + 108'($signed(p.hl));
    ll  = 108'($signed(p.ll));
    return (hh <<< 54) + (mid <<< 27) + ll;
  endfunction

  function automatic part64_t pmul64(input logic signed [63:0] x,
                                     input logic signed [63:0] y);
    part64_t p;
    logic signed [32:0] xl, yl;
    logic signed [31:0] xh, yh;
    xl = $signed({1'b0, x[31:0]});
    yl = $signed({1'b0, y[31:0]});
    xh = x[63:32];
    yh = y[63:32];
    p.ll = xl * yl;
    p.lh = xl * yh;
    p.hl = xh * yl;
    p.hh = xh * yh;
    return p;
  endfunction

  function automatic logic signed [127:0] pjoin64(input part64_t p);
    logic signed [127:0] hh, mid, ll;
    hh  = 128'($signed(p.hh));
    mid = 128'($signed(p.lh)) + 128'($signed(p.hl));
    ll  = 128'($signed(p.ll));
    return (hh <<< 64) + (mid <<< 32) + ll;
  endfunction

  // clamp to +-(2^62-1)
  function automatic logic signed [62:0] sat62(input logic signed [127:0] x);
    logic signed [62:0] r;
    if (x > LIM_W) begin
      r = LIM63;
    end else if (x < -LIM_W) begin
      r = -LIM63;
    end else begin
      r = x[62:0];
    end
    return r;
  endfunction

  // clamp to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [50:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ray_cone_intersection.sv =====
// ray versus double cone intersection, fully pipelined, one ray per clock
// Takes one ray in every clock cycle (busy is always low) and returns one result per
// ray, in order, as a one-cycle strobe on out_valid; the receiver cannot stall and
// needs none. The pipeline is made up mainly of the square root of the discriminant
// (one result bit per stage, 64 stages) and the two root dividers (31 quotient bits,
// one per stage); the rest is the dot products and the quadratic terms, with wide
// multiplies split over two stages. Cone registers are read by the pipeline as items
// pass, so write them only while no ray is in flight.
module ray_cone_intersection
  import rci_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // ray input
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_ray_origin_x,
  input  logic signed [31:0]  in_ray_origin_y,
  input  logic signed [31:0]  in_ray_origin_z,
  input  logic signed [17:0]  in_ray_dir_x,
  input  logic signed [17:0]  in_ray_dir_y,
  input  logic signed [17:0]  in_ray_dir_z,
  // results
  output logic                out_valid,
  output logic                out_hit_valid,
  output logic [30:0]         out_hit_distance,
  output logic signed [31:0]  out_hit_x,
  output logic signed [31:0]  out_hit_y,
  output logic signed [31:0]  out_hit_z,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int SQ     = 64;
  localparam int DQ     = 31;
  localparam int K_SQ0  = 10;
  localparam int LAST   = K_SQ0 + SQ + 3 + DQ + 3;
  localparam int NBW    = 67 - FRAC_BITS;
  localparam int RW     = (65 + FRAC_BITS > 96) ? 66 + FRAC_BITS : 97;
  localparam logic [63:0] EPS_A_RAW = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] EPS_A     = (EPS_A_RAW == 64'd0) ? 64'd1 : EPS_A_RAW;
  localparam logic [63:0] EPS_D     = ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;

  // configuration registers
  logic signed [31:0] apex_r [3];
  logic signed [17:0] axis_r [3];
  logic [16:0]        cs_r;
  logic [30:0]        far_r;

  // pipeline control and ray line
  logic [LAST:0] v_r;
  ray_t          ray_r [0:LAST-1];

  // dot product stages
  logic signed [32:0]    co_r  [3];
  logic signed [35:0]    pda_r [3];
  logic signed [50:0]    pca_r [3];
  logic signed [50:0]    pdc_r [3];
  logic signed [65:0]    pcc_r [3];
  logic signed [37:0]    nda_r;
  logic signed [52:0]    bda_r;
  logic signed [52:0]    ndb_r;
  logic signed [NBW-1:0] nbbf_r;
  logic signed [67:0]    nbb;

  // quadratic terms
  part54_t                  pnn_r, pnb_r, pbb_r;
  logic signed [70:0]       pdcs_r, pdcs5_r;
  logic signed [NBW+17:0]   pncs_r, pncs5_r;
  logic signed [107:0]      pnn5_r, pnb5_r, pbb5_r;
  logic signed [63:0]       a6_r;
  logic signed [62:0]       t1_r, t2_r, u1_r, u2_r;
  logic signed [63:0]       diff;
  logic [63:0]              amag;
  logic signed [63:0]       a7_r, a8_r, a9_r, a10_r;
  logic signed [62:0]       b7_r, b8_r, b9_r, b10_r, c7_r;
  logic                     ma7_r, ma8_r, ma9_r, m10_r;
  part64_t                  pbb8_r, pac8_r;
  logic signed [127:0]      bb9_r, ac9_r, dl10_r, delta;

  // square root line
  logic [66:0]        sq_rem_r  [0:SQ-1];
  logic [63:0]        sq_root_r [0:SQ-1];
  logic [127:0]       sq_x_r    [0:SQ-1];
  logic signed [63:0] sq_a_r    [0:SQ-1];
  logic signed [62:0] sq_b_r    [0:SQ-1];
  logic               sq_m_r    [0:SQ-1];

  // root numerators and divider set-up
  logic signed [65:0] nb66, s66;
  logic signed [65:0] sn_r, sp_r;
  logic signed [64:0] den_r;
  logic               m75_r;
  logic [64:0]        magn, magp, magd;
  logic [RW-1:0]      mg_mn_r, mg_mp_r;
  logic [64:0]        mg_d_r;
  logic               mg_negn_r, mg_negp_r, mg_aneg_r, mg_m_r;
  logic [RW-1:0]      dvi_rn_r, dvi_rp_r, dlim;
  logic [64:0]        dvi_d_r;
  div_side_t          dvi_side_r;

  // divider line
  logic [RW-1:0]      dv_rn_r   [0:DQ-1];
  logic [RW-1:0]      dv_rp_r   [0:DQ-1];
  logic [DQ-1:0]      dv_qn_r   [0:DQ-1];
  logic [DQ-1:0]      dv_qp_r   [0:DQ-1];
  logic [64:0]        dv_d_r    [0:DQ-1];
  div_side_t          dv_side_r [0:DQ-1];

  // root selection and hit point
  div_side_t          fs;
  logic [DQ-1:0]      qn, qp;
  logic               nneg, pneg, fneg, sneg;
  logic [30:0]        valn, valp, fval, sval;
  logic               hit109_r, hit110_r;
  logic [30:0]        dist109_r, dist110_r;
  logic signed [49:0] pm_r [3];

  logic               hit_valid_r;
  logic [30:0]        hit_dist_r;
  logic signed [31:0] hit_r [3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apex_r[0] <= '0;
      apex_r[1] <= '0;
      apex_r[2] <= '0;
      axis_r[0] <= '0;
      axis_r[1] <= 18'sd65536;
      axis_r[2] <= '0;
      cs_r      <= 17'd49152;
      far_r     <= DIST_SAT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_APEX_X: apex_r[0] <= cfg_data;
        REG_APEX_Y: apex_r[1] <= cfg_data;
        REG_APEX_Z: apex_r[2] <= cfg_data;
        REG_AXIS_X: axis_r[0] <= cfg_data[17:0];
        REG_AXIS_Y: axis_r[1] <= cfg_data[17:0];
        REG_AXIS_Z: axis_r[2] <= cfg_data[17:0];
        REG_COS_SQ: cs_r      <= cfg_data[16:0];
        REG_FAR:    far_r     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with the items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LAST-1:0], start & ~busy};
    end
  end

  // ray capture and delay line
  always_ff @(posedge clk) begin
    ray_r[0].o[0] <= in_ray_origin_x;
    ray_r[0].o[1] <= in_ray_origin_y;
    ray_r[0].o[2] <= in_ray_origin_z;
    ray_r[0].d[0] <= in_ray_dir_x;
    ray_r[0].d[1] <= in_ray_dir_y;
    ray_r[0].d[2] <= in_ray_dir_z;
    for (int k = 1; k < LAST; k++) begin
      ray_r[k] <= ray_r[k-1];
    end
  end

  // origin relative to apex, then the dot product terms
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      co_r[i]  <= 33'($signed(ray_r[0].o[i])) - 33'(apex_r[i]);
      pda_r[i] <= $signed(ray_r[1].d[i]) * axis_r[i];
      pca_r[i] <= co_r[i] * axis_r[i];
      pdc_r[i] <= $signed(ray_r[1].d[i]) * co_r[i];
      pcc_r[i] <= co_r[i] * co_r[i];
    end
  end

  // sums of the dot products
  assign nbb = 68'(pcc_r[0]) + 68'(pcc_r[1]) + 68'(pcc_r[2]);

  always_ff @(posedge clk) begin
    nda_r  <= 38'(pda_r[0]) + 38'(pda_r[1]) + 38'(pda_r[2]);
    bda_r  <= 53'(pca_r[0]) + 53'(pca_r[1]) + 53'(pca_r[2]);
    ndb_r  <= 53'(pdc_r[0]) + 53'(pdc_r[1]) + 53'(pdc_r[2]);
    nbbf_r <= NBW'(nbb >>> FRAC_BITS);
  end

  // product terms of a, b and c, wide ones over two stages
  always_ff @(posedge clk) begin
    pnn_r   <= pmul54(54'(nda_r), 54'(nda_r));
    pnb_r   <= pmul54(54'(nda_r), 54'(bda_r));
    pbb_r   <= pmul54(54'(bda_r), 54'(bda_r));
    pdcs_r  <= ndb_r * $signed({1'b0, cs_r});
    pncs_r  <= nbbf_r * $signed({1'b0, cs_r});
    pnn5_r  <= pjoin54(pnn_r);
    pnb5_r  <= pjoin54(pnb_r);
    pbb5_r  <= pjoin54(pbb_r);
    pdcs5_r <= pdcs_r;
    pncs5_r <= pncs_r;
  end

  // scale and saturate each term
  always_ff @(posedge clk) begin
    a6_r <= 64'(sat62(128'(pnn5_r >>> (3 * FRAC_BITS)))) - 64'($signed({1'b0, cs_r}));
    t1_r <= sat62(128'(pnb5_r >>> (3 * FRAC_BITS)));
    t2_r <= sat62(128'(pdcs5_r >>> (2 * FRAC_BITS)));
    u1_r <= sat62(128'(pbb5_r >>> (3 * FRAC_BITS)));
    u2_r <= sat62(128'(pncs5_r >>> FRAC_BITS));
  end

  // coefficients a, b, c and the flat quadratic test
  assign diff = 64'(t1_r) - 64'(t2_r);
  assign amag = a6_r[63] ? 64'(-a6_r) : 64'(a6_r);

  always_ff @(posedge clk) begin
    a7_r  <= a6_r;
    ma7_r <= amag < EPS_A;
    c7_r  <= sat62(128'(64'(u1_r) - 64'(u2_r)));
    if (diff > HALF64) begin
      b7_r <= LIM63;
    end else if (diff < -HALF64) begin
      b7_r <= -LIM63;
    end else begin
      b7_r <= 63'(diff <<< 1);
    end
  end

  // discriminant over three stages
  assign delta = bb9_r - (ac9_r <<< 2);

  always_ff @(posedge clk) begin
    pbb8_r <= pmul64(64'(b7_r), 64'(b7_r));
    pac8_r <= pmul64(a7_r, 64'(c7_r));
    a8_r   <= a7_r;
    b8_r   <= b7_r;
    ma8_r  <= ma7_r;
    bb9_r  <= pjoin64(pbb8_r);
    ac9_r  <= pjoin64(pac8_r);
    a9_r   <= a8_r;
    b9_r   <= b8_r;
    ma9_r  <= ma8_r;
    dl10_r <= delta;
    a10_r  <= a9_r;
    b10_r  <= b9_r;
    m10_r  <= ma9_r | !($signed({64'd0, EPS_D}) < delta);
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    logic [66:0]        rem_in, cur, trial;
    logic [63:0]        root_in;
    logic [127:0]       x_in;
    logic signed [63:0] a_in;
    logic signed [62:0] b_in;
    logic               m_in, fits;
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = dl10_r;
      assign a_in    = a10_r;
      assign b_in    = b10_r;
      assign m_in    = m10_r;
    end else begin : g_next
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
      assign x_in    = sq_x_r[j-1];
      assign a_in    = sq_a_r[j-1];
      assign b_in    = sq_b_r[j-1];
      assign m_in    = sq_m_r[j-1];
    end
    assign cur   = {rem_in[64:0], x_in[127:126]};
    assign trial = {1'b0, root_in, 2'b01};
    assign fits  = cur >= trial;
    always_ff @(posedge clk) begin
      sq_rem_r[j]  <= fits ? cur - trial : cur;
      sq_root_r[j] <= {root_in[62:0], fits};
      sq_x_r[j]    <= {x_in[125:0], 2'b00};
      sq_a_r[j]    <= a_in;
      sq_b_r[j]    <= b_in;
      sq_m_r[j]    <= m_in;
    end
  end

  // root numerators -b - s and -b + s, denominator 2a
  assign nb66 = -(66'(sq_b_r[SQ-1]));
  assign s66  = $signed({2'b00, sq_root_r[SQ-1]});

  always_ff @(posedge clk) begin
    sn_r  <= nb66 - s66;
    sp_r  <= nb66 + s66;
    den_r <= 65'(sq_a_r[SQ-1]) <<< 1;
    m75_r <= sq_m_r[SQ-1];
  end

  // magnitudes and quotient signs
  assign magn = sn_r[65] ? 65'(-sn_r) : 65'(sn_r);
  assign magp = sp_r[65] ? 65'(-sp_r) : 65'(sp_r);
  assign magd = den_r[64] ? 65'(-den_r) : 65'(den_r);

  always_ff @(posedge clk) begin
    mg_mn_r   <= RW'(magn) << FRAC_BITS;
    mg_mp_r   <= RW'(magp) << FRAC_BITS;
    mg_d_r    <= magd;
    mg_negn_r <= sn_r[65] ^ den_r[64];
    mg_negp_r <= sp_r[65] ^ den_r[64];
    mg_aneg_r <= den_r[64];
    mg_m_r    <= m75_r;
  end

  // quotient overflow beyond the distance range
  assign dlim = RW'(mg_d_r) << DQ;

  always_ff @(posedge clk) begin
    dvi_rn_r        <= mg_mn_r;
    dvi_rp_r        <= mg_mp_r;
    dvi_d_r         <= mg_d_r;
    dvi_side_r.ovfn <= mg_mn_r >= dlim;
    dvi_side_r.ovfp <= mg_mp_r >= dlim;
    dvi_side_r.negn <= mg_negn_r;
    dvi_side_r.negp <= mg_negp_r;
    dvi_side_r.aneg <= mg_aneg_r;
    dvi_side_r.miss <= mg_m_r;
  end

  // restoring dividers for both roots, one quotient bit per stage
  for (genvar j = 0; j < DQ; j++) begin : g_div
    logic [RW-1:0] rn_in, rp_in, dsh;
    logic [DQ-1:0] qn_in, qp_in;
    logic [64:0]   d_in;
    div_side_t     side_in;
    logic          fitn, fitp;
    if (j == 0) begin : g_first
      assign rn_in   = dvi_rn_r;
      assign rp_in   = dvi_rp_r;
      assign qn_in   = '0;
      assign qp_in   = '0;
      assign d_in    = dvi_d_r;
      assign side_in = dvi_side_r;
    end else begin : g_next
      assign rn_in   = dv_rn_r[j-1];
      assign rp_in   = dv_rp_r[j-1];
      assign qn_in   = dv_qn_r[j-1];
      assign qp_in   = dv_qp_r[j-1];
      assign d_in    = dv_d_r[j-1];
      assign side_in = dv_side_r[j-1];
    end
    assign dsh  = RW'(d_in) << (DQ - 1 - j);
    assign fitn = rn_in >= dsh;
    assign fitp = rp_in >= dsh;
    always_ff @(posedge clk) begin
      dv_rn_r[j]   <= fitn ? rn_in - dsh : rn_in;
      dv_rp_r[j]   <= fitp ? rp_in - dsh : rp_in;
      dv_qn_r[j]   <= {qn_in[DQ-2:0], fitn};
      dv_qp_r[j]   <= {qp_in[DQ-2:0], fitp};
      dv_d_r[j]    <= d_in;
      dv_side_r[j] <= side_in;
    end
  end

  // pick the nearer root in front of the origin
  assign fs   = dv_side_r[DQ-1];
  assign qn   = dv_qn_r[DQ-1];
  assign qp   = dv_qp_r[DQ-1];
  assign nneg = fs.negn && (fs.ovfn || (qn != '0));
  assign pneg = fs.negp && (fs.ovfp || (qp != '0));
  assign valn = fs.ovfn ? DIST_SAT : qn;
  assign valp = fs.ovfp ? DIST_SAT : qp;
  assign fneg = fs.aneg ? pneg : nneg;
  assign sneg = fs.aneg ? nneg : pneg;
  assign fval = fs.aneg ? valp : valn;
  assign sval = fs.aneg ? valn : valp;

  always_ff @(posedge clk) begin
    hit109_r  <= !fs.miss && !(fneg && sneg);
    dist109_r <= fneg ? sval : fval;
  end

  // hit point: direction times distance, then offset and clamp
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pm_r[i] <= $signed(ray_r[LAST-2].d[i]) * $signed({1'b0, dist109_r});
    end
    hit110_r  <= hit109_r;
    dist110_r <= dist109_r;
  end

  // output register
  always_ff @(posedge clk) begin
    hit_valid_r <= hit110_r;
    hit_dist_r  <= hit110_r ? dist110_r : far_r;
    for (int i = 0; i < 3; i++) begin
      hit_r[i] <= hit110_r
                  ? sat32(51'($signed(ray_r[LAST-1].o[i])) + 51'(pm_r[i] >>> FRAC_BITS))
                  : '0;
    end
  end

  assign out_valid        = v_r[LAST];
  assign out_hit_valid    = hit_valid_r;
  assign out_hit_distance = hit_dist_r;
  assign out_hit_x        = hit_r[0];
  assign out_hit_y        = hit_r[1];
  assign out_hit_z        = hit_r[2];

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the ray versus double cone intersection block
module tb
  import rci_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC     = 16;
  localparam longint LIM      = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint EPS_A    = 7;
  localparam longint EPS_D    = 429497;
  localparam int     LATENCY  = 111;

  typedef struct {
    logic        hit;
    logic [30:0] hit_dist;
    coord_t      x, y, z;
  } cone_hit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  coord_t      in_ray_origin_x = '0, in_ray_origin_y = '0, in_ray_origin_z = '0;
  unit_t       in_ray_dir_x = '0, in_ray_dir_y = '0, in_ray_dir_z = '0;
  logic        out_valid, out_hit_valid;
  logic [30:0] out_hit_distance;
  coord_t      out_hit_x, out_hit_y, out_hit_z;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // cone registers as the block should hold them
  coord_t      cone_apex [3];
  unit_t       cone_axis [3];
  logic [16:0] cone_cos_sq;
  logic [30:0] cone_far;

  ray_t        rays_pending [$];
  cone_hit_t   hits_expected [$];
  int          mismatches = 0;
  bit          hold = 1'b0;
  bit          no_gaps = 1'b0;

  ray_cone_intersection u_top (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [127:0] wide(input longint v);
    logic signed [127:0] r;
    r = v;
    return r;
  endfunction

  // clamp a wide value to +-(2^62-1)
  function automatic longint clamp62(input logic signed [127:0] v);
    if (v > wide(LIM)) return LIM;
    if (v < -wide(LIM)) return -LIM;
    return longint'(v);
  endfunction

  function automatic coord_t clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return coord_t'(v);
  endfunction

  // expected outcome of one ray against the current cone
  function automatic cone_hit_t cone_hit(input ray_t r);
    cone_hit_t           h;
    longint              o [3], d [3], bo [3];
    longint              nda, bda, ndb, nbbf, a, b, c, t1, t2, diff, cs;
    logic signed [127:0] nbb, delta, nb, den, tn, tp, first, second, tsel, sroot;
    logic [127:0]        sq;
    logic [63:0]         s, trial;
    nda = 0; bda = 0; ndb = 0; nbb = '0;
    cs = longint'(cone_cos_sq);
    for (int i = 0; i < 3; i++) begin
      o[i]  = r.o[i];
      d[i]  = r.d[i];
      bo[i] = o[i] - longint'(cone_apex[i]);
      nda  += d[i] * longint'(cone_axis[i]);
      bda  += bo[i] * longint'(cone_axis[i]);
      ndb  += d[i] * bo[i];
      nbb  += wide(bo[i]) * wide(bo[i]);
    end
    nbbf = clamp62(nbb >>> FRAC);
    a  = clamp62((wide(nda) * wide(nda)) >>> (3 * FRAC)) - cs;
    t1 = clamp62((wide(nda) * wide(bda)) >>> (3 * FRAC));
    t2 = clamp62((wide(ndb) * wide(cs)) >>> (2 * FRAC));
    diff = t1 - t2;
    b = diff > LIM / 2 ? LIM : (diff < -(LIM / 2) ? -LIM : 2 * diff);
    t1 = clamp62((wide(bda) * wide(bda)) >>> (3 * FRAC));
    t2 = clamp62((wide(nbbf) * wide(cs)) >>> FRAC);
    c = clamp62(wide(t1) - wide(t2));
    h.hit = 1'b0; h.hit_dist = cone_far; h.x = '0; h.y = '0; h.z = '0;
    // flat quadratic
    if ((a < 0 ? -a : a) < EPS_A) return h;
    delta = wide(b) * wide(b) - ((wide(a) * wide(c)) <<< 2);
    // discriminant too small or negative
    if (delta <= wide(EPS_D)) return h;
    s = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = s | (64'd1 << i);
      sq = {64'd0, trial} * {64'd0, trial};
      if (sq <= $unsigned(delta)) s = trial;
    end
    sroot = $signed({64'd0, s});
    nb  = -wide(b);
    den = wide(2 * a);
    tn = ((nb - sroot) <<< FRAC) / den;
    tp = ((nb + sroot) <<< FRAC) / den;
    first  = a < 0 ? tp : tn;
    second = a < 0 ? tn : tp;
    if (first >= 0) tsel = first;
    else if (second >= 0) tsel = second;
    else return h;
    // roots both behind the origin are handled above
    h.hit      = 1'b1;
    h.hit_dist = tsel > wide(64'h7FFF_FFFF) ? 31'h7FFF_FFFF : tsel[30:0];
    h.x = clamp32(o[0] + ((d[0] * longint'(h.hit_dist)) >>> FRAC));
    h.y = clamp32(o[1] + ((d[1] * longint'(h.hit_dist)) >>> FRAC));
    h.z = clamp32(o[2] + ((d[2] * longint'(h.hit_dist)) >>> FRAC));
    return h;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // ray driver: new ray presented at the falling edge
  always @(negedge clk) begin
    if (rst_n && rays_pending.size() > 0 && !hold &&
        (no_gaps || $urandom_range(99) >= 23)) begin
      start <= 1'b1;
      in_ray_origin_x <= rays_pending[0].o[0];
      in_ray_origin_y <= rays_pending[0].o[1];
      in_ray_origin_z <= rays_pending[0].o[2];
      in_ray_dir_x    <= rays_pending[0].d[0];
      in_ray_dir_y    <= rays_pending[0].d[1];
      in_ray_dir_z    <= rays_pending[0].d[2];
    end else begin
      start <= 1'b0;
    end
  end

  // ray transfer: predict its result
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      hits_expected.push_back(cone_hit(rays_pending[0]));
      void'(rays_pending.pop_front());
    end
  end

  // result monitor
  always @(posedge clk) begin
    cone_hit_t e;
    if (rst_n && out_valid) begin
      if (hits_expected.size() == 0) begin
        report("unexpected result", out_hit_distance, 0);
      end else begin
        e = hits_expected.pop_front();
        if (out_hit_valid !== e.hit) report("hit_valid", out_hit_valid, e.hit);
        if (out_hit_distance !== e.hit_dist)
          report("hit_distance", out_hit_distance, e.hit_dist);
        if (out_hit_x !== e.x) report("hit_x", out_hit_x, e.x);
        if (out_hit_y !== e.y) report("hit_y", out_hit_y, e.y);
        if (out_hit_z !== e.z) report("hit_z", out_hit_z, e.z);
      end
    end
  end

  // one register write over the configuration channel
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_APEX_X: cone_apex[0] = val;
      REG_APEX_Y: cone_apex[1] = val;
      REG_APEX_Z: cone_apex[2] = val;
      REG_AXIS_X: cone_axis[0] = val[17:0];
      REG_AXIS_Y: cone_axis[1] = val[17:0];
      REG_AXIS_Z: cone_axis[2] = val[17:0];
      REG_COS_SQ: cone_cos_sq  = val[16:0];
      REG_FAR:    cone_far     = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_cone(input coord_t ap [3], input unit_t ax [3],
                            input logic [16:0] cs, input logic [30:0] far);
    write_reg(REG_APEX_X, ap[0]);
    write_reg(REG_APEX_Y, ap[1]);
    write_reg(REG_APEX_Z, ap[2]);
    write_reg(REG_AXIS_X, 32'(ax[0]));
    write_reg(REG_AXIS_Y, 32'(ax[1]));
    write_reg(REG_AXIS_Z, 32'(ax[2]));
    write_reg(REG_COS_SQ, 32'(cs));
    write_reg(REG_FAR, 32'(far));
  endtask

  task automatic add_ray(input coord_t ox, oy, oz, input unit_t dx, dy, dz);
    ray_t r;
    r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
    r.d[0] = dx; r.d[1] = dy; r.d[2] = dz;
    rays_pending.push_back(r);
  endtask

  // mostly unit-range directions near the cone, some full-width noise
  task automatic add_random_rays(input int n);
    coord_t o [3];
    unit_t  d [3];
    int     kind;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
        if (kind < 7) begin
          o[i] = $signed($urandom_range(20 << 16)) - (10 << 16);
          d[i] = 18'($signed($urandom_range(131072)) - 65536);
        end else begin
          o[i] = $urandom;
          d[i] = 18'($urandom);
        end
      end
      add_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    end
  endtask

  task automatic drain;
    wait (rays_pending.size() == 0 && hits_expected.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // stimulus
  initial begin
    coord_t ap [3];
    unit_t  ax [3];
    cone_apex   = '{0, 0, 0};
    cone_axis   = '{0, 18'sd65536, 0};
    cone_cos_sq = 17'd49152;
    cone_far    = 31'h7FFF_FFFF;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rays against the reset cone
    add_ray(0, -(5 << 16), 0, 0, 18'sd65536, 0);             // along the axis
    add_ray(0, 5 << 16, 0, 0, -18'sd65536, 0);
    add_ray(3 << 16, 4 << 16, 0, -18'sd65536, 0, 0);         // across the cone
    add_ray(3 << 16, 4 << 16, 0, 18'sd65536, 0, 0);          // roots behind
    add_ray(0, 0, 0, 0, 0, 0);                               // zero direction
    add_ray(1 << 16, 0, 0, 0, 0, 0);
    add_ray(0, 10 << 16, 0, 0, 0, 18'sd65536);               // grazing slope
    add_ray(0, 0, 0, 0, 18'sd56756, 18'sd32768);             // flat quadratic
    add_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            18'sd65536, 18'sd65536, 18'sd65536);
    add_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            -18'sd65536, -18'sd65536, -18'sd65536);
    add_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 18'sh1FFFF, 18'sh20000, 18'sh1FFFF);
    add_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF,
            18'sh20000, 18'sh1FFFF, 18'sh20000);
    add_ray(0, 32'sh4000_0000, 0, 0, -18'sd65536, 1);        // far hit saturates
    add_ray(0, -(1 << 16), 0, 0, 18'sd65536, 0);
    add_ray(1, 1, 1, 1, 1, 1);
    add_ray(-1, -1, -1, -1, -1, -1);
    add_ray(0, 2 << 16, 2 << 16, 0, 0, -18'sd65536);
    add_ray(0, 2 << 16, 1 << 16, 0, -18'sd46341, -18'sd46341);
    drain();

    // random cone near the origin, with a forced pause mid-way
    for (int i = 0; i < 3; i++) begin
      ap[i] = $signed($urandom_range(4 << 16)) - (2 << 16);
      ax[i] = 18'($signed($urandom_range(131072)) - 65536);
    end
    write_cone(ap, ax, 17'($urandom_range(65536)), 31'($urandom));
    add_random_rays(100);
    wait (rays_pending.size() == 0);
    hold = 1'b1;
    wait (hits_expected.size() == 0);
    hold = 1'b0;
    add_random_rays(100);
    drain();

    // extreme registers, no gaps on the sender
    ap = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0};
    ax = '{-18'sd65536, 18'sd65536, 0};
    write_cone(ap, ax, 17'd0, 31'd0);
    no_gaps = 1'b1;
    add_random_rays(80);
    drain();
    no_gaps = 1'b0;

    ap = '{0, 0, 0};
    ax = '{0, 0, 18'sd65536};
    write_cone(ap, ax, 17'd65536, 31'h7FFF_FFFF);
    add_random_rays(80);
    drain();

    // registers loaded with full-width random values, cos squared with all ones
    ap = '{32'($urandom), 32'($urandom), 32'($urandom)};
    ax = '{18'($urandom), 18'($urandom), 18'($urandom)};
    write_cone(ap, ax, 17'h1FFFF, 31'($urandom));
    add_random_rays(60);
    drain();

    // a narrow cone tilted off axis
    ap = '{1 << 16, -(1 << 16), 0};
    ax = '{18'sd46341, 18'sd46341, 0};
    write_cone(ap, ax, 17'd60000, 31'h1234_5678);
    add_random_rays(150);
    drain();

    if (mismatches == 0) begin
      $display("PASS ray_cone_intersection");
    end else begin
      $display("FAIL ray_cone_intersection");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("FAIL ray_cone_intersection");
    $finish;
  end

endmodule
